[hdl/dpfrc_pkg.sv]
//------------------------------------------------------------------------------
// Distinct prime factor range count: shared definitions
// Field widths, default sizes and the build sequencer states.
//------------------------------------------------------------------------------
`default_nettype none

package dpfrc_pkg;

   localparam int MAX_VALUE_DEF = 4096;
   localparam int MAX_K_DEF     = 5;

   localparam int BOUND_W       = 13;
   localparam int KSEL_W        = 3;
   localparam int COUNT_W       = 13;
   localparam int OMEGA_W       = 3;

   localparam int REQ_TDATA_W   = 32;
   localparam int RSP_TDATA_W   = 16;

   typedef enum logic [2:0] {
      BUILD_CLEAR,
      BUILD_CHECK,
      BUILD_EVAL,
      BUILD_MARK,
      BUILD_PREFIX,
      BUILD_FINISH,
      BUILD_READY
   } build_state_type;

endpackage

`default_nettype wire

[hdl/dpfrc_ram.sv]
//------------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
//------------------------------------------------------------------------------
`default_nettype none

module dpfrc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

[hdl/dpfrc_build.sv]
//------------------------------------------------------------------------------
// Start-up table builder
// Clears the factor count and prefix memories, sieves the factor counts and writes the prefix count rows.
//------------------------------------------------------------------------------
`default_nettype none

module dpfrc_build
   import dpfrc_pkg::*;
#(
   parameter int MAX_VALUE = MAX_VALUE_DEF,
   parameter int MAX_K     = MAX_K_DEF,
   localparam int ADDR_W   = $clog2(MAX_VALUE + 1),
   localparam int CNT_W    = $clog2(MAX_VALUE + 1)
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   output logic                          pfx_wr_en,
   output logic [ADDR_W-1:0]             pfx_wr_addr,
   output logic [MAX_K*CNT_W-1:0]        pfx_wr_data,
   output logic                          build_done
);

   localparam int IDX_W = ADDR_W + 1;
   localparam logic [IDX_W-1:0] LAST = IDX_W'(MAX_VALUE);

   build_state_type     state_ff, state_in;
   logic [IDX_W-1:0]    i_ff, i_in;
   logic [IDX_W-1:0]    j_ff, j_in;
   logic [IDX_W-1:0]    j_next;
   logic                mark_pend_ff, mark_pend_in;
   logic                pref_pend_ff, pref_pend_in;
   logic [ADDR_W-1:0]   pend_addr_ff, pend_addr_in;
   logic [CNT_W-1:0]    cnt_ff [MAX_K];
   logic [CNT_W-1:0]    cnt_in [MAX_K];
   logic                done_ff, done_in;

   logic                om_wr_en;
   logic [ADDR_W-1:0]   om_wr_addr;
   logic [OMEGA_W-1:0]  om_wr_data;
   logic [ADDR_W-1:0]   om_rd_addr;
   logic [OMEGA_W-1:0]  om_rd_data;

   dpfrc_ram #(
      .WIDTH (OMEGA_W),
      .DEPTH (MAX_VALUE + 1)
   ) u_omega_ram (
      .clock   (clock),
      .wr_en   (om_wr_en),
      .wr_addr (om_wr_addr),
      .wr_data (om_wr_data),
      .rd_addr (om_rd_addr),
      .rd_data (om_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BUILD_CLEAR;
         i_ff         <= '0;
         j_ff         <= '0;
         mark_pend_ff <= 1'b0;
         pref_pend_ff <= 1'b0;
         done_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         mark_pend_ff <= mark_pend_in;
         pref_pend_ff <= pref_pend_in;
         done_ff      <= done_in;
      end
      pend_addr_ff <= pend_addr_in;
      cnt_ff       <= cnt_in;
   end

   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      j_next       = j_ff + i_ff;
      mark_pend_in = 1'b0;
      pref_pend_in = 1'b0;
      pend_addr_in = pend_addr_ff;
      done_in      = done_ff;
      cnt_in       = cnt_ff;
      om_rd_addr   = i_ff[ADDR_W-1:0];
      om_wr_en     = 1'b0;
      om_wr_addr   = pend_addr_ff;
      om_wr_data   = om_rd_data + OMEGA_W'(1);
      pfx_wr_en    = 1'b0;
      pfx_wr_addr  = pend_addr_ff;
      pfx_wr_data  = '0;

      if (mark_pend_ff) begin
         om_wr_en = 1'b1;
      end

      if (pref_pend_ff) begin
         for (int k = 0; k < MAX_K; k++) begin
            cnt_in[k] = cnt_ff[k]
                      + CNT_W'({1'b0, om_rd_data} == (OMEGA_W + 1)'(k + 1));
            pfx_wr_data[k*CNT_W +: CNT_W] = cnt_in[k];
         end
         pfx_wr_en = 1'b1;
      end

      case (state_ff)
         BUILD_CLEAR: begin
            om_wr_en    = 1'b1;
            om_wr_addr  = i_ff[ADDR_W-1:0];
            om_wr_data  = '0;
            pfx_wr_en   = 1'b1;
            pfx_wr_addr = i_ff[ADDR_W-1:0];
            pfx_wr_data = '0;
            if (i_ff == LAST) begin
               i_in     = IDX_W'(2);
               state_in = BUILD_CHECK;
            end else begin
               i_in = i_ff + IDX_W'(1);
            end
         end
         BUILD_CHECK: begin
            if (i_ff > LAST) begin
               j_in     = IDX_W'(1);
               for (int k = 0; k < MAX_K; k++) begin
                  cnt_in[k] = '0;
               end
               state_in = BUILD_PREFIX;
            end else begin
               state_in = BUILD_EVAL;
            end
         end
         BUILD_EVAL: begin
            if (om_rd_data == '0) begin
               j_in     = i_ff;
               state_in = BUILD_MARK;
            end else begin
               i_in     = i_ff + IDX_W'(1);
               state_in = BUILD_CHECK;
            end
         end
         BUILD_MARK: begin
            om_rd_addr   = j_ff[ADDR_W-1:0];
            mark_pend_in = 1'b1;
            pend_addr_in = j_ff[ADDR_W-1:0];
            j_in         = j_next;
            if (j_next > LAST) begin
               i_in     = i_ff + IDX_W'(1);
               state_in = BUILD_CHECK;
            end
         end
         BUILD_PREFIX: begin
            om_rd_addr   = j_ff[ADDR_W-1:0];
            pref_pend_in = 1'b1;
            pend_addr_in = j_ff[ADDR_W-1:0];
            j_in         = j_ff + IDX_W'(1);
            if (j_ff == LAST) begin
               state_in = BUILD_FINISH;
            end
         end
         BUILD_FINISH: begin
            done_in  = 1'b1;
            state_in = BUILD_READY;
         end
         BUILD_READY: begin
            done_in = 1'b1;
         end
         default: begin
            state_in = BUILD_CLEAR;
         end
      endcase
   end

   assign build_done = done_ff;

endmodule

`default_nettype wire

[hdl/dpfrc_query.sv]
//------------------------------------------------------------------------------
// Range query pipeline
// Reads two prefix rows, subtracts the selected column, queues the result.
//------------------------------------------------------------------------------
`default_nettype none

module dpfrc_query
   import dpfrc_pkg::*;
#(
   parameter int MAX_VALUE = MAX_VALUE_DEF,
   parameter int MAX_K     = MAX_K_DEF,
   localparam int ADDR_W   = $clog2(MAX_VALUE + 1),
   localparam int CNT_W    = $clog2(MAX_VALUE + 1)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   build_done,
   input  wire logic                   pfx_wr_en,
   input  wire logic [ADDR_W-1:0]      pfx_wr_addr,
   input  wire logic [MAX_K*CNT_W-1:0] pfx_wr_data,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata
);

   localparam int IDX_W   = ADDR_W + 1;
   localparam int EXT_W   = (IDX_W > BOUND_W) ? IDX_W : BOUND_W;
   localparam int DIFF_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
   localparam int FIFO_D  = 3;
   localparam logic [EXT_W-1:0] LAST = EXT_W'(MAX_VALUE);

   logic [BOUND_W-1:0]      low_bound;
   logic [BOUND_W-1:0]      high_bound;
   logic [KSEL_W-1:0]       factor_count;
   logic [EXT_W-1:0]        lo_ext, hi_ext, lo_m1;
   logic                    ok_in;
   logic                    accept;

   logic [MAX_K*CNT_W-1:0]  hi_row, lo_row;
   logic                    s1_valid_ff, s1_ok_ff;
   logic [KSEL_W-1:0]       s1_col_ff;
   logic [CNT_W-1:0]        hi_col, lo_col, diff;
   logic [DIFF_W-1:0]       diff_ext;
   logic [COUNT_W-1:0]      s1_result;

   logic [COUNT_W-1:0]      fifo_mem_ff [FIFO_D];
   logic [1:0]              wr_ptr_ff, rd_ptr_ff, cnt_ff;
   logic                    pop;
   logic [2:0]              occupancy;

   assign low_bound    = req_tdata[BOUND_W-1:0];
   assign high_bound   = req_tdata[2*BOUND_W-1:BOUND_W];
   assign factor_count = req_tdata[2*BOUND_W+KSEL_W-1:2*BOUND_W];

   always_comb begin
      lo_ext = EXT_W'(low_bound);
      if (low_bound == '0) begin
         lo_ext = EXT_W'(1);
      end
      if (lo_ext > LAST) begin
         lo_ext = LAST;
      end
      hi_ext = EXT_W'(high_bound);
      if (hi_ext > LAST) begin
         hi_ext = LAST;
      end
      lo_m1 = lo_ext - EXT_W'(1);
      ok_in = (factor_count != '0)
           && ({1'b0, factor_count} <= (KSEL_W + 1)'(MAX_K))
           && (lo_ext <= hi_ext);
   end

   assign occupancy  = {1'b0, cnt_ff} + {2'b00, s1_valid_ff};
   assign req_tready = build_done && (occupancy < 3'(FIFO_D));
   assign accept     = req_tvalid && req_tready;

   dpfrc_ram #(
      .WIDTH (MAX_K * CNT_W),
      .DEPTH (MAX_VALUE + 1)
   ) u_hi_ram (
      .clock   (clock),
      .wr_en   (pfx_wr_en),
      .wr_addr (pfx_wr_addr),
      .wr_data (pfx_wr_data),
      .rd_addr (hi_ext[ADDR_W-1:0]),
      .rd_data (hi_row)
   );

   dpfrc_ram #(
      .WIDTH (MAX_K * CNT_W),
      .DEPTH (MAX_VALUE + 1)
   ) u_lo_ram (
      .clock   (clock),
      .wr_en   (pfx_wr_en),
      .wr_addr (pfx_wr_addr),
      .wr_data (pfx_wr_data),
      .rd_addr (lo_m1[ADDR_W-1:0]),
      .rd_data (lo_row)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      s1_ok_ff  <= ok_in;
      s1_col_ff <= factor_count - KSEL_W'(1);
   end

   always_comb begin
      hi_col = '0;
      lo_col = '0;
      for (int c = 0; c < MAX_K; c++) begin
         if (s1_col_ff == KSEL_W'(c)) begin
            hi_col = hi_row[c*CNT_W +: CNT_W];
            lo_col = lo_row[c*CNT_W +: CNT_W];
         end
      end
      diff      = hi_col - lo_col;
      diff_ext  = DIFF_W'(diff);
      s1_result = s1_ok_ff ? diff_ext[COUNT_W-1:0] : '0;
   end

   assign pop = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (s1_valid_ff) begin
            wr_ptr_ff <= (wr_ptr_ff == 2'(FIFO_D - 1)) ? 2'd0 : wr_ptr_ff + 2'd1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == 2'(FIFO_D - 1)) ? 2'd0 : rd_ptr_ff + 2'd1;
         end
         cnt_ff <= cnt_ff + 2'(s1_valid_ff) - 2'(pop);
      end
      if (s1_valid_ff) begin
         fifo_mem_ff[wr_ptr_ff] <= s1_result;
      end
   end

   assign rsp_tvalid = (cnt_ff != '0);
   assign rsp_tdata  = RSP_TDATA_W'(fifo_mem_ff[rd_ptr_ff]);

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(s1_valid_ff && !pop && cnt_ff == 2'(FIFO_D)))
      else $error("Result queue overflow.");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      build_done |=> build_done)
      else $error("Build done flag fell.");

   a_no_write_after_done: assert property (@(posedge clock) disable iff (reset)
      build_done |-> !pfx_wr_en)
      else $error("Prefix table written after the build.");

   a_invalid_gives_zero: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_ok_ff) |-> (s1_result == '0))
      else $error("Invalid query gave a non-zero count.");

endmodule

`default_nettype wire

[hdl/distinct_prime_factor_range_count_top.sv]
//------------------------------------------------------------------------------
// Distinct prime factor range count
// Counts the values in an inclusive range with exactly k distinct prime factors.
//------------------------------------------------------------------------------
// Queries arrive as beats on the req_ channel and each gives one result beat
// on the rsp_ channel, in order. A query beat holds the lower bound, the upper
// bound and the factor count; the result beat holds the matching count.
// After reset the block builds its tables before it raises req_tready: a
// clearing pass over both memories, a sieve that checks each candidate value
// and marks each multiple of each prime, and a prefix pass. Once built, one
// query is accepted per cycle while the result queue has room. The prefix
// memory reads for a query beat are registered, and the subtraction then
// writes its result into the result queue. The two reads use two copies of
// the prefix memory, written together during the build. A three-beat result
// queue absorbs a stalled receiver; req_tready falls only when that queue and
// the read stage together hold three results.
//------------------------------------------------------------------------------
`default_nettype none

module distinct_prime_factor_range_count_top
   import dpfrc_pkg::*;
#(
   parameter int MAX_VALUE = MAX_VALUE_DEF,
   parameter int MAX_K     = MAX_K_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // low_bound [12:0], high_bound [25:13], factor_count [28:26], zero [31:29]
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // matching_count [12:0], zero [15:13]
   output logic [RSP_TDATA_W-1:0]      rsp_tdata
);

   localparam int ADDR_W = $clog2(MAX_VALUE + 1);
   localparam int CNT_W  = $clog2(MAX_VALUE + 1);

   logic                   pfx_wr_en;
   logic [ADDR_W-1:0]      pfx_wr_addr;
   logic [MAX_K*CNT_W-1:0] pfx_wr_data;
   logic                   build_done;

   dpfrc_build #(
      .MAX_VALUE (MAX_VALUE),
      .MAX_K     (MAX_K)
   ) u_build (
      .clock       (clock),
      .reset       (reset),
      .pfx_wr_en   (pfx_wr_en),
      .pfx_wr_addr (pfx_wr_addr),
      .pfx_wr_data (pfx_wr_data),
      .build_done  (build_done)
   );

   dpfrc_query #(
      .MAX_VALUE (MAX_VALUE),
      .MAX_K     (MAX_K)
   ) u_query (
      .clock       (clock),
      .reset       (reset),
      .build_done  (build_done),
      .pfx_wr_en   (pfx_wr_en),
      .pfx_wr_addr (pfx_wr_addr),
      .pfx_wr_data (pfx_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

`default_nettype wire

[sim/dpfrc_count_monitor.sv]
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// Distinct prime factor range count: channel monitor and result checker
// Watches both stream channels and works out the expected count for every
// accepted query beat from its own sieve and running totals. It compares each
// result beat with the oldest expected count. Failures and the number of
// queries still waiting for a result go back to the testbench top.
//------------------------------------------------------------------------------

module dpfrc_count_monitor
   import dpfrc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   // low_bound [12:0], high_bound [25:13], factor_count [28:26], zero [31:29]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // matching_count [12:0], zero [15:13]
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   output int                     failures,
   output int                     outstanding
);

   localparam int HIGH_LSB = BOUND_W;
   localparam int KSEL_LSB = 2 * BOUND_W;

   int omega_of [0:MAX_VALUE_DEF];
   int running_total [0:MAX_VALUE_DEF][1:MAX_K_DEF];

   logic [COUNT_W-1:0] expected_counts [$];
   int queries_seen = 0;
   int results_seen = 0;
   int mismatch_total = 0;

   assign failures    = mismatch_total;
   assign outstanding = queries_seen - results_seen;

   initial begin : build_tables
      int value;
      int multiple;
      int kk;
      for (value = 0; value <= MAX_VALUE_DEF; value++)
         omega_of[value] = 0;
      for (value = 2; value <= MAX_VALUE_DEF; value++) begin
         if (omega_of[value] == 0) begin
            for (multiple = value; multiple <= MAX_VALUE_DEF; multiple += value)
               omega_of[multiple]++;
         end
      end
      for (kk = 1; kk <= MAX_K_DEF; kk++)
         running_total[0][kk] = 0;
      for (value = 1; value <= MAX_VALUE_DEF; value++) begin
         for (kk = 1; kk <= MAX_K_DEF; kk++)
            running_total[value][kk] = running_total[value-1][kk]
                                       + ((omega_of[value] == kk) ? 1 : 0);
      end
   end

   function automatic logic [COUNT_W-1:0] count_in_range(
      input logic [BOUND_W-1:0] low_raw,
      input logic [BOUND_W-1:0] high_raw,
      input logic [KSEL_W-1:0]  factor_count
   );
      int low_value;
      int high_value;
      int total;
      low_value  = int'(low_raw);
      high_value = int'(high_raw);
      if (low_value == 0)
         low_value = 1;
      if (low_value > MAX_VALUE_DEF)
         low_value = MAX_VALUE_DEF;
      if (high_value > MAX_VALUE_DEF)
         high_value = MAX_VALUE_DEF;
      if (factor_count == 0 || factor_count > MAX_K_DEF || low_value > high_value)
         return '0;
      total = running_total[high_value][factor_count]
              - running_total[low_value-1][factor_count];
      return total[COUNT_W-1:0];
   endfunction

   always @(posedge clock) begin : watch_beats
      logic [COUNT_W-1:0] wanted;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_counts.push_back(count_in_range(req_tdata[BOUND_W-1:0],
                                                     req_tdata[HIGH_LSB +: BOUND_W],
                                                     req_tdata[KSEL_LSB +: KSEL_W]));
            queries_seen++;
         end
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (expected_counts.size() == 0) begin
               $error("matching_count: expected none, got %0d",
                      rsp_tdata[COUNT_W-1:0]);
               mismatch_total++;
            end else begin
               wanted = expected_counts.pop_front();
               if (rsp_tdata[COUNT_W-1:0] !== wanted) begin
                  $error("matching_count: expected %0d, got %0d",
                         wanted, rsp_tdata[COUNT_W-1:0]);
                  mismatch_total++;
               end
            end
         end
      end
   end

endmodule

[sim/tb_distinct_prime_factor_range_count_top.sv]
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// Distinct prime factor range count: testbench top
// Resets the block, waits out its table build through the handshake and then
// sends directed range queries followed by shaped random ones, with random
// gaps and result stalls, one long result hold-off and one drain pause.
// Checking is done by the monitor beside the block.
//------------------------------------------------------------------------------

module tb_distinct_prime_factor_range_count_top;
   import dpfrc_pkg::*;

   localparam int RANDOM_QUERIES = 1600;
   localparam int HOLD_CYCLES    = 120;
   localparam int IDLE_LIMIT     = 200000;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   int failures;
   int outstanding;
   int idle_cycles = 0;
   bit calm        = 1'b0;
   bit rsp_hold    = 1'b0;
   int burst_left  = 0;

   always #6 clock = ~clock;

   distinct_prime_factor_range_count_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   dpfrc_count_monitor count_monitor (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .failures    (failures),
      .outstanding (outstanding)
   );

   // The block accepts nothing during its table build after reset, so the limit
   // is set well above the build time.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   function automatic logic [BOUND_W-1:0] extreme_bound();
      case ($urandom_range(0, 6))
         0:       return 13'd0;
         1:       return 13'd1;
         2:       return 13'd2;
         3:       return 13'd4095;
         4:       return 13'd4096;
         5:       return 13'd4097;
         default: return 13'd8191;
      endcase
   endfunction

   task automatic send_query(
      input logic [BOUND_W-1:0] low_bound,
      input logic [BOUND_W-1:0] high_bound,
      input logic [KSEL_W-1:0]  factor_count
   );
      int gap;
      gap = (calm || burst_left > 0) ? 0 : $urandom_range(0, 3);
      if (burst_left > 0)
         burst_left--;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {3'b000, factor_count, high_bound, low_bound};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   initial begin : result_sink
      int stall;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (rsp_hold) begin
            rsp_hold = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            stall = calm ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin : query_source
      int                 n;
      int                 pick;
      int                 span;
      logic [BOUND_W-1:0] low_bound;
      logic [BOUND_W-1:0] high_bound;
      logic [KSEL_W-1:0]  factor_count;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed queries: whole table for every factor count, single values,
      // zero and saturating bounds, empty ranges and unused factor counts.
      for (n = 1; n <= MAX_K_DEF; n++)
         send_query(13'd0, 13'd4096, n[KSEL_W-1:0]);
      send_query(13'd0, 13'd0, 3'd1);
      send_query(13'd1, 13'd1, 3'd1);
      send_query(13'd2, 13'd2, 3'd1);
      send_query(13'd4096, 13'd4096, 3'd1);
      send_query(13'd8191, 13'd8191, 3'd1);
      send_query(13'd0, 13'd8191, 3'd2);
      send_query(13'd5000, 13'd6000, 3'd1);
      send_query(13'd4000, 13'd10, 3'd3);
      send_query(13'd8191, 13'd0, 3'd2);
      send_query(13'd2310, 13'd2310, 3'd5);
      send_query(13'd30, 13'd30, 3'd3);
      send_query(13'd1, 13'd4096, 3'd0);
      send_query(13'd1, 13'd4096, 3'd6);
      send_query(13'd1, 13'd4096, 3'd7);
      send_query(13'd5461, 13'd2730, 3'd4);
      send_query(13'd2730, 13'd5461, 3'd4);

      for (n = 0; n < RANDOM_QUERIES; n++) begin
         if (n % 150 == 0)
            calm = ($urandom_range(0, 3) == 0);
         if (n == 300) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (outstanding != 0) @(posedge clock);
            @(posedge clock);
         end
         if (n == 700) begin
            rsp_hold   = 1'b1;
            burst_left = 40;
         end
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            span         = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 64)
                                                       : $urandom_range(0, 4096);
            low_bound    = BOUND_W'($urandom_range(0, 4096));
            high_bound   = (int'(low_bound) + span > 8191) ? 13'd8191
                                                           : BOUND_W'(int'(low_bound) + span);
            factor_count = KSEL_W'($urandom_range(1, MAX_K_DEF));
         end else if (pick < 80) begin
            low_bound    = BOUND_W'($urandom_range(0, 8191));
            high_bound   = BOUND_W'($urandom_range(0, 8191));
            factor_count = KSEL_W'($urandom_range(0, 7));
         end else if (pick < 90) begin
            high_bound   = BOUND_W'($urandom_range(0, 4095));
            low_bound    = BOUND_W'(int'(high_bound)
                                    + $urandom_range(1, 8191 - high_bound));
            factor_count = KSEL_W'($urandom_range(0, 7));
         end else begin
            low_bound    = extreme_bound();
            high_bound   = extreme_bound();
            factor_count = KSEL_W'($urandom_range(0, 7));
         end
         send_query(low_bound, high_bound, factor_count);
      end
      req_tvalid <= 1'b0;
      @(posedge clock);

      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

[distinct_prime_factor_range_count_top.f]
hdl/dpfrc_pkg.sv
hdl/dpfrc_ram.sv
hdl/dpfrc_build.sv
hdl/dpfrc_query.sv
hdl/distinct_prime_factor_range_count_top.sv
sim/dpfrc_count_monitor.sv
sim/tb_distinct_prime_factor_range_count_top.sv
